// ===== rtl/bsc_pkg.sv =====
package bsc_pkg;

    localparam int ADC_T_W = 20;
    localparam int ADC_P_W = 20;
    localparam int ADC_H_W = 16;
    localparam int TC_W = 18;
    localparam int FT_W = 24;
    localparam int PQ_W = 32;
    localparam int HQ_W = 17;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int DIV_W = 64;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_TEMP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_LO = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_HI = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_P9 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HUM_MAIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HUM_OFS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HUM_EN = 3'd6;

    typedef struct packed {
        logic [47:0] temp;
        logic [63:0] press_lo;
        logic [63:0] press_hi;
        logic [15:0] p9;
        logic [39:0] hum_main;
        logic [23:0] hum_ofs;
        logic        hum_en;
    } cfg_t;

    typedef struct packed {
        logic [ADC_H_W-1:0] adc_humidity;
        logic [ADC_P_W-1:0] adc_pressure;
        logic [ADC_T_W-1:0] adc_temperature;
    } in_t;

    typedef struct packed {
        logic [HQ_W-1:0] humidity_q22_10;
        logic            pressure_div_zero;
        logic [PQ_W-1:0] pressure_q24_8;
        logic [FT_W-1:0] fine_temperature;
        logic [TC_W-1:0] temperature_centi;
    } res_t;

    // Results that ride alongside the pressure division.
    typedef struct packed {
        logic [TC_W-1:0] tc;
        logic [FT_W-1:0] ft;
        logic [HQ_W-1:0] hq;
        logic            dz;
        logic            neg;
    } tag_t;

endpackage

// ===== rtl/bsc_queue.sv =====
module bsc_queue #(
    parameter int DEPTH = bsc_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  bsc_pkg::in_t  push_data,
    output logic          pop_valid,
    input  logic          pop_ready,
    output bsc_pkg::in_t  pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    bsc_pkg::in_t      mem_reg [0:DEPTH-1];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/bsc_div.sv =====
module bsc_div #(
    parameter int W = bsc_pkg::DIV_W
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  logic          in_valid,
    input  logic [W-1:0]  in_num,
    input  logic [W-1:0]  in_den,
    input  bsc_pkg::tag_t in_tag,
    output logic          out_valid,
    output logic [W-1:0]  out_quo,
    output bsc_pkg::tag_t out_tag
);

    // One quotient bit per stage, restoring division on magnitudes.
    logic          v_reg   [0:W];
    logic [W-1:0]  rem_reg [0:W];
    logic [W-1:0]  nq_reg  [0:W];
    logic [W-1:0]  den_reg [0:W];
    bsc_pkg::tag_t tag_reg [0:W];

    always_comb
    begin
        v_reg[0]   = in_valid;
        rem_reg[0] = '0;
        nq_reg[0]  = in_num;
        den_reg[0] = in_den;
        tag_reg[0] = in_tag;
    end

    for (genvar i = 1; i <= W; i++)
    begin : g_stage
        logic [W:0] trial;
        logic       ge;

        always_comb
        begin
            trial = {rem_reg[i-1], nq_reg[i-1][W-1]};
            ge    = (trial >= {1'b0, den_reg[i-1]});
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else if (adv)
            begin
                v_reg[i] <= v_reg[i-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[i] <= ge ? W'(trial - {1'b0, den_reg[i-1]}) : trial[W-1:0];
                nq_reg[i]  <= {nq_reg[i-1][W-2:0], ge};
                den_reg[i] <= den_reg[i-1];
                tag_reg[i] <= tag_reg[i-1];
            end
        end
    end

    assign out_valid = v_reg[W];
    assign out_quo   = nq_reg[W];
    assign out_tag   = tag_reg[W];

endmodule

// ===== rtl/bsc_back.sv =====
module bsc_back (
    input  logic          clk,
    input  logic          rst_n,
    input  bsc_pkg::cfg_t cfg,
    input  logic          in_valid,
    output logic          in_ready,
    input  bsc_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output bsc_pkg::res_t out_data
);

    typedef struct packed {
        logic [bsc_pkg::TC_W-1:0] tc;
        logic [bsc_pkg::FT_W-1:0] ft;
    } side_t;

    logic adv;
    logic out_valid_reg;
    bsc_pkg::res_t out_data_reg;

    assign adv       = !out_valid_reg || out_ready;
    assign in_ready  = adv;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Coefficients.
    logic [31:0] t1w, t2w, t3w;
    logic [15:0] p1u;
    logic signed [15:0] p2s, p3s, p5s, p6s, p8s, p9s;
    logic [15:0] p4r, p7r;
    logic [31:0] p3w, p6w, p8w, p9w;
    logic [31:0] h1w, h2w, h3w, h4w, h5w, h6w;

    always_comb
    begin
        t1w = {16'b0, cfg.temp[15:0]};
        t2w = {{16{cfg.temp[31]}}, cfg.temp[31:16]};
        t3w = {{16{cfg.temp[47]}}, cfg.temp[47:32]};
        p1u = cfg.press_lo[15:0];
        p2s = cfg.press_lo[31:16];
        p3s = cfg.press_lo[47:32];
        p4r = cfg.press_lo[63:48];
        p5s = cfg.press_hi[15:0];
        p6s = cfg.press_hi[31:16];
        p7r = cfg.press_hi[47:32];
        p8s = cfg.press_hi[63:48];
        p9s = cfg.p9;
        p3w = {{16{p3s[15]}}, p3s};
        p6w = {{16{p6s[15]}}, p6s};
        p8w = {{16{p8s[15]}}, p8s};
        p9w = {{16{p9s[15]}}, p9s};
        h1w = {24'b0, cfg.hum_main[7:0]};
        h2w = {{16{cfg.hum_main[23]}}, cfg.hum_main[23:8]};
        h3w = {24'b0, cfg.hum_main[31:24]};
        h6w = {{24{cfg.hum_main[39]}}, cfg.hum_main[39:32]};
        h4w = {{20{cfg.hum_ofs[11]}}, cfg.hum_ofs[11:0]};
        h5w = {{20{cfg.hum_ofs[23]}}, cfg.hum_ofs[23:12]};
    end

    // Valid chain of the front stages.
    logic v_reg [0:13];

    // Stage registers.
    logic [19:0] at_reg;
    logic [19:0] ap_reg [0:7];
    logic [15:0] ah_reg [0:4];
    logic [31:0] m1_reg, bb_reg;
    logic [31:0] v1_reg, m2_reg;
    logic [31:0] tf_reg;
    side_t       sd_reg [4:12];
    logic signed [33:0] w1_reg;
    logic [31:0] aw_reg, hx5_reg, xh6_reg, xh3_reg;
    logic [63:0] sq_reg;
    logic signed [63:0] w1p5_reg, w1p2_reg;
    logic signed [63:0] w1p5d_reg, w1p2d_reg;
    logic [31:0] s1_reg [5:9];
    logic [31:0] ta_reg, ub_reg;
    logic signed [63:0] lo6_reg, lo3_reg;
    logic [31:0] hi6_reg, hi3_reg;
    logic [31:0] tu_reg;
    logic [63:0] w2_reg, w1a_reg;
    logic [31:0] wc_reg;
    logic [63:0] elo_reg;
    logic [31:0] ehi_reg;
    logic [63:0] nlo_reg;
    logic [31:0] nhi_reg;
    logic [31:0] wh2_reg;
    logic [63:0] dd_reg [9:12];
    logic [63:0] nn_reg [9:12];
    logic [31:0] r_reg;
    logic [31:0] sr_reg [10:12];
    logic [31:0] qq_reg;
    logic [31:0] qqh_reg;
    logic [63:0] un_reg, ud_reg;
    bsc_pkg::tag_t tag13_reg;

    // Stage combinational values.
    logic [31:0] a1, b1;
    logic signed [31:0] bbs, m1s, m2s;
    logic [31:0] bbsh;
    logic [31:0] tf5, hx;
    logic signed [33:0] w1c;
    logic signed [63:0] w1p5c, w1p2c;
    logic [31:0] hsum;
    logic signed [31:0] hsums, xh6s, xh3s, tus, wh2s, srs, qqs, qqhs, hxs;
    logic signed [63:0] lo6c, lo3c;
    logic [63:0] sum3;
    logic signed [63:0] sum3s;
    logic [63:0] e8, n0;
    logic [20:0] prr;
    logic [63:0] eprod;
    logic signed [63:0] eprods;
    logic [31:0] r9;
    logic [31:0] q11;
    logic [31:0] x13;
    logic [16:0] hq13;
    logic [63:0] nn12, dd12;

    always_comb
    begin
        a1    = {15'b0, at_reg[19:3]} - {15'b0, t1w[15:0], 1'b0};
        b1    = {16'b0, at_reg[19:4]} - t1w;
        bbs   = bb_reg;
        bbsh  = 32'(bbs >>> 12);
        m1s   = m1_reg;
        m2s   = m2_reg;
        tf5   = tf_reg * 32'd5 + 32'd128;
        w1c   = {{2{tf_reg[31]}}, tf_reg} - 34'sd128000;
        hx    = tf_reg - 32'd76800;
        w1p5c = w1_reg * p5s;
        w1p2c = w1_reg * p2s;
        hsum  = {2'b0, ah_reg[4], 14'b0} - {h4w[11:0], 20'b0} - hx5_reg + 32'd16384;
        hsums = hsum;
        xh6s  = xh6_reg;
        xh3s  = xh3_reg;
        lo6c  = $signed({1'b0, sq_reg[31:0]}) * p6s;
        lo3c  = $signed({1'b0, sq_reg[31:0]}) * p3s;
        tus   = tu_reg;
        sum3  = 64'(lo3_reg) + {hi3_reg, 32'b0};
        sum3s = sum3;
        e8    = 64'h0000_8000_0000_0000 + w1a_reg;
        prr   = 21'h100000 - {1'b0, ap_reg[7]};
        n0    = {12'b0, prr, 31'b0} - w2_reg;
        eprod = elo_reg + {ehi_reg, 32'b0};
        eprods = eprod;
        wh2s  = wh2_reg + 32'd8192;
        r9    = 32'(wh2s >>> 14);
        srs   = sr_reg[10];
        q11   = 32'(srs >>> 15);
        qqs   = qq_reg;
        qqhs  = qqh_reg;
        hxs   = sr_reg[12] - 32'(qqhs >>> 4);
        x13   = hxs;
        if (hxs < 0)
        begin
            x13 = '0;
        end
        else if (hxs > 32'sd419430400)
        begin
            x13 = 32'd419430400;
        end
        hq13  = cfg.hum_en ? x13[28:12] : '0;
        nn12  = nn_reg[12];
        dd12  = dd_reg[12];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= 13; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            v_reg[0] <= in_valid;
            for (int i = 1; i <= 13; i++)
            begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            at_reg    <= in_data.adc_temperature;
            ap_reg[0] <= in_data.adc_pressure;
            ah_reg[0] <= in_data.adc_humidity;
            for (int i = 1; i <= 7; i++)
            begin
                ap_reg[i] <= ap_reg[i-1];
            end
            for (int i = 1; i <= 4; i++)
            begin
                ah_reg[i] <= ah_reg[i-1];
            end
            // Temperature.
            m1_reg <= a1 * t2w;
            bb_reg <= b1 * b1;
            v1_reg <= 32'(m1s >>> 11);
            m2_reg <= bbsh * t3w;
            tf_reg <= v1_reg + 32'(m2s >>> 14);
            // Split into output widths; the full word feeds the other channels.
            sd_reg[4] <= '{tc: tf5[25:8], ft: tf_reg[23:0]};
            for (int i = 5; i <= 12; i++)
            begin
                sd_reg[i] <= sd_reg[i-1];
            end
            w1_reg  <= w1c;
            aw_reg  <= w1c[33] ? 32'(-w1c) : w1c[31:0];
            hx5_reg <= hx * h5w;
            xh6_reg <= hx * h6w;
            xh3_reg <= hx * h3w;
            // Pressure, first half.
            sq_reg   <= {32'b0, aw_reg} * {32'b0, aw_reg};
            w1p5_reg <= w1p5c;
            w1p2_reg <= w1p2c;
            // Line the linear terms up with the squared terms.
            w1p5d_reg <= w1p5_reg;
            w1p2d_reg <= w1p2_reg;
            s1_reg[5] <= 32'(hsums >>> 15);
            for (int i = 6; i <= 9; i++)
            begin
                s1_reg[i] <= s1_reg[i-1];
            end
            ta_reg  <= 32'(xh6s >>> 10);
            ub_reg  <= 32'(xh3s >>> 11) + 32'd32768;
            lo6_reg <= lo6c;
            lo3_reg <= lo3c;
            hi6_reg <= sq_reg[63:32] * p6w;
            hi3_reg <= sq_reg[63:32] * p3w;
            tu_reg  <= ta_reg * ub_reg;
            w2_reg  <= 64'(lo6_reg) + {hi6_reg, 32'b0} + {w1p5d_reg[46:0], 17'b0}
                       + {{13{p4r[15]}}, p4r, 35'b0};
            w1a_reg <= 64'(sum3s >>> 8) + {w1p2d_reg[51:0], 12'b0};
            wc_reg  <= 32'(tus >>> 10) + 32'd2097152;
            elo_reg <= {32'b0, e8[31:0]} * {48'b0, p1u};
            ehi_reg <= e8[63:32] * {16'b0, p1u};
            nlo_reg <= {32'b0, n0[31:0]} * 64'd3125;
            nhi_reg <= n0[63:32] * 32'd3125;
            wh2_reg <= wc_reg * h2w;
            dd_reg[9] <= 64'(eprods >>> 33);
            nn_reg[9] <= nlo_reg + {nhi_reg, 32'b0};
            for (int i = 10; i <= 12; i++)
            begin
                dd_reg[i] <= dd_reg[i-1];
                nn_reg[i] <= nn_reg[i-1];
            end
            r_reg  <= r9;
            sr_reg[10] <= s1_reg[9] * r_reg;
            sr_reg[11] <= sr_reg[10];
            sr_reg[12] <= sr_reg[11];
            qq_reg  <= q11 * q11;
            qqh_reg <= 32'(qqs >>> 7) * h1w;
            un_reg  <= nn12[63] ? 64'(-nn12) : nn12;
            ud_reg  <= dd12[63] ? 64'(-dd12) : dd12;
            tag13_reg <= '{tc: sd_reg[12].tc, ft: sd_reg[12].ft, hq: hq13,
                           dz: (dd12 == '0), neg: nn12[63] ^ dd12[63]};
        end
    end

    // Pressure division.
    logic          dv_valid;
    logic [63:0]   dv_quo;
    bsc_pkg::tag_t dv_tag;

    bsc_div #(
        .W(bsc_pkg::DIV_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (v_reg[13]),
        .in_num   (un_reg),
        .in_den   (ud_reg),
        .in_tag   (tag13_reg),
        .out_valid(dv_valid),
        .out_quo  (dv_quo),
        .out_tag  (dv_tag)
    );

    // Pressure, second half.
    logic va_reg, vb_reg, vc_reg;
    logic [63:0] pra_reg, prb_reg, prc_reg;
    bsc_pkg::tag_t taga_reg, tagb_reg, tagc_reg;
    logic [63:0] lolo_reg;
    logic [31:0] lohi_reg;
    logic signed [63:0] lo8_reg;
    logic [31:0] hi8_reg;
    logic [63:0] hh_reg, p8pr_reg, p8prc_reg;
    logic signed [63:0] lo9_reg;
    logic [31:0] hi9_reg;

    logic [63:0] pra;
    logic signed [63:0] pras, hs;
    logic [63:0] hhc;
    logic signed [63:0] p9hh, p8prs, sumo, pr2;
    logic [31:0] pq;

    always_comb
    begin
        pra   = dv_tag.neg ? 64'(-dv_quo) : dv_quo;
        pras  = pra;
        hs    = pras >>> 13;
        hhc   = lolo_reg + {lohi_reg[30:0], 33'b0};
        p9hh  = lo9_reg + $signed({hi9_reg, 32'b0});
        p8prs = p8prc_reg;
        sumo  = $signed(prc_reg) + (p9hh >>> 25) + (p8prs >>> 19);
        pr2   = (sumo >>> 8) + $signed({{44{p7r[15]}}, p7r, 4'b0});
        if (tagc_reg.dz || pr2 < 0)
        begin
            pq = '0;
        end
        else if (pr2[63:32] != '0)
        begin
            pq = '1;
        end
        else
        begin
            pq = pr2[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg        <= 1'b0;
            vb_reg        <= 1'b0;
            vc_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            va_reg        <= dv_valid;
            vb_reg        <= va_reg;
            vc_reg        <= vb_reg;
            out_valid_reg <= vc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pra_reg  <= pra;
            taga_reg <= dv_tag;
            lolo_reg <= {32'b0, hs[31:0]} * {32'b0, hs[31:0]};
            lohi_reg <= hs[31:0] * hs[63:32];
            lo8_reg  <= $signed({1'b0, pra[31:0]}) * p8s;
            hi8_reg  <= pra[63:32] * p8w;
            prb_reg  <= pra_reg;
            tagb_reg <= taga_reg;
            hh_reg   <= hhc;
            p8pr_reg <= 64'(lo8_reg) + {hi8_reg, 32'b0};
            prc_reg  <= prb_reg;
            tagc_reg <= tagb_reg;
            lo9_reg  <= $signed({1'b0, hh_reg[31:0]}) * p9s;
            hi9_reg  <= hh_reg[63:32] * p9w;
            p8prc_reg <= p8pr_reg;
            out_data_reg <= '{humidity_q22_10: tagc_reg.hq,
                              pressure_div_zero: tagc_reg.dz,
                              pressure_q24_8: pq,
                              fine_temperature: tagc_reg.ft,
                              temperature_centi: tagc_reg.tc};
        end
    end

endmodule

// ===== rtl/barometric_sensor_compensation.sv =====
// Integer compensation of one raw temperature, pressure and humidity conversion.
// Configuration: write cfg_we with cfg_index and cfg_data while the block is idle;
// the seven calibration registers take the low bits of cfg_data.
// Input channel s_axis: tdata carries the temperature, pressure and humidity codes.
// Output channel m_axis: tdata carries temperature in 0.01 degC, the fine
// temperature, pressure in Pa*256 and humidity in %RH*1024; tuser is raised when
// the pressure divisor was zero and pressure was forced to zero.
// Each input transaction gives exactly one output transaction, in order.
// Throughput is one transaction per cycle while the output is not stalled. From
// input acceptance to output valid a transaction passes the input queue,
// fourteen stages of temperature, humidity and pressure setup, the first loaded
// by the queue pop, a 64-stage one-bit-per-stage pressure divider and four finishing stages.
// When m_axis_tvalid is high and m_axis_tready low the whole pipeline holds;
// the four-entry input queue keeps accepting until it fills, then
// s_axis_tready drops.
// Reset clears all calibration registers to zero, empties the queue and
// drops all valid flags; no output is pending after reset.
module barometric_sensor_compensation #(
    parameter int QUEUE_DEPTH = bsc_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // adc_temperature[19:0], adc_pressure[39:20], adc_humidity[55:40]
    input  logic [55:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // temperature_centi[17:0], fine_temperature[41:18], pressure_q24_8[73:42],
    // humidity_q22_10[90:74], zero padding above
    output logic [95:0] m_axis_tdata,
    // pressure_div_zero[0]
    output logic        m_axis_tuser
);

    bsc_pkg::cfg_t cfg_reg;
    bsc_pkg::in_t  q_data;
    bsc_pkg::res_t res;
    logic          q_valid;
    logic          q_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bsc_pkg::REG_TEMP:     cfg_reg.temp     <= cfg_data[47:0];
                bsc_pkg::REG_PRESS_LO: cfg_reg.press_lo <= cfg_data;
                bsc_pkg::REG_PRESS_HI: cfg_reg.press_hi <= cfg_data;
                bsc_pkg::REG_PRESS_P9: cfg_reg.p9       <= cfg_data[15:0];
                bsc_pkg::REG_HUM_MAIN: cfg_reg.hum_main <= cfg_data[39:0];
                bsc_pkg::REG_HUM_OFS:  cfg_reg.hum_ofs  <= cfg_data[23:0];
                bsc_pkg::REG_HUM_EN:   cfg_reg.hum_en   <= cfg_data[0];
                default:               cfg_reg          <= cfg_reg;
            endcase
        end
    end

    bsc_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_valid(s_axis_tvalid),
        .push_ready(s_axis_tready),
        .push_data (bsc_pkg::in_t'(s_axis_tdata)),
        .pop_valid (q_valid),
        .pop_ready (q_ready),
        .pop_data  (q_data)
    );

    bsc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (q_valid),
        .in_ready (q_ready),
        .in_data  (q_data),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .out_data (res)
    );

    assign m_axis_tdata = {5'b0, res.humidity_q22_10, res.pressure_q24_8,
                           res.fine_temperature, res.temperature_centi};
    assign m_axis_tuser = res.pressure_div_zero;

endmodule

// ===== test/barometric_sensor_compensation_tb.sv =====
`timescale 1ns / 100ps

module barometric_sensor_compensation_tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 120;
    localparam int LONG_HOLD = 300;

    typedef struct packed {
        logic [bsc_pkg::TC_W-1:0] tc;
        logic [bsc_pkg::FT_W-1:0] ft;
        logic [bsc_pkg::PQ_W-1:0] pq;
        logic                     dz;
        logic [bsc_pkg::HQ_W-1:0] hq;
    } reading_t;

    typedef struct {
        bsc_pkg::in_t conv;
        logic         typed;
        reading_t     want;
    } vector_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;
    logic        m_axis_tuser;

    barometric_sensor_compensation dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    always #1 clk = ~clk;

    // Shadow copy of the calibration registers.
    logic [47:0] cal_temp = '0;
    logic [63:0] cal_press_lo = '0;
    logic [63:0] cal_press_hi = '0;
    logic [15:0] cal_p9 = '0;
    logic [39:0] cal_hum_main = '0;
    logic [23:0] cal_hum_ofs = '0;
    logic        cal_hum_en = 1'b0;

    reading_t pending_readings[$];
    int       mismatches = 0;
    int       cycle_count = 0;
    bit       idling_on = 1'b1;
    bit       hold_request = 1'b0;
    int       hold_left = 0;
    int       sink_stall = 0;

    function automatic logic [31:0] sra32(logic [31:0] x, int s);
        return $unsigned($signed(x) >>> s);
    endfunction

    function automatic logic [63:0] sra64(logic [63:0] x, int s);
        return $unsigned($signed(x) >>> s);
    endfunction

    function automatic logic [63:0] sx16to64(logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic logic [63:0] div_trunc(logic [63:0] n, logic [63:0] d);
        logic [63:0] un, ud, q;
        un = n[63] ? 64'd0 - n : n;
        ud = d[63] ? 64'd0 - d : d;
        q = un / ud;
        return (n[63] != d[63]) ? 64'd0 - q : q;
    endfunction

    function automatic reading_t compensate(bsc_pkg::in_t c);
        reading_t r;
        logic [31:0] at, ah, t1, t2, t3, a, b, v1, v2, tf, tc;
        logic [63:0] w1, w2, pr, hh, ap;
        logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [31:0] h1, h2, h3, h4, h5, h6, x, s1, ta, ub, wc, rr, q;
        at = 32'(c.adc_temperature);
        ah = 32'(c.adc_humidity);
        ap = 64'(c.adc_pressure);
        t1 = {16'd0, cal_temp[15:0]};
        t2 = {{16{cal_temp[31]}}, cal_temp[31:16]};
        t3 = {{16{cal_temp[47]}}, cal_temp[47:32]};
        a = (at >> 3) - (t1 << 1);
        v1 = sra32(a * t2, 11);
        b = (at >> 4) - t1;
        v2 = sra32(sra32(b * b, 12) * t3, 14);
        tf = v1 + v2;
        tc = sra32(tf * 32'd5 + 32'd128, 8);
        r.tc = tc[bsc_pkg::TC_W-1:0];
        r.ft = tf[bsc_pkg::FT_W-1:0];

        p1 = {48'd0, cal_press_lo[15:0]};
        p2 = sx16to64(cal_press_lo[31:16]);
        p3 = sx16to64(cal_press_lo[47:32]);
        p4 = sx16to64(cal_press_lo[63:48]);
        p5 = sx16to64(cal_press_hi[15:0]);
        p6 = sx16to64(cal_press_hi[31:16]);
        p7 = sx16to64(cal_press_hi[47:32]);
        p8 = sx16to64(cal_press_hi[63:48]);
        p9 = sx16to64(cal_p9);
        w1 = {{32{tf[31]}}, tf} - 64'd128000;
        w2 = w1 * w1 * p6;
        w2 = w2 + ((w1 * p5) << 17);
        w2 = w2 + (p4 << 35);
        w1 = sra64(w1 * w1 * p3, 8) + ((w1 * p2) << 12);
        w1 = sra64(((64'd1 << 47) + w1) * p1, 33);
        r.pq = '0;
        r.dz = (w1 == 64'd0);
        if (!r.dz)
        begin
            pr = 64'd1048576 - ap;
            pr = div_trunc(((pr << 31) - w2) * 64'd3125, w1);
            hh = sra64(pr, 13);
            w1 = sra64(p9 * hh * hh, 25);
            w2 = sra64(p8 * pr, 19);
            pr = sra64(pr + w1 + w2, 8) + (p7 << 4);
            if (pr[63])
                r.pq = '0;
            else if (pr[63:32] != 32'd0)
                r.pq = '1;
            else
                r.pq = pr[31:0];
        end

        r.hq = '0;
        if (cal_hum_en)
        begin
            h1 = {24'd0, cal_hum_main[7:0]};
            h2 = {{16{cal_hum_main[23]}}, cal_hum_main[23:8]};
            h3 = {24'd0, cal_hum_main[31:24]};
            h6 = {{24{cal_hum_main[39]}}, cal_hum_main[39:32]};
            h4 = {{20{cal_hum_ofs[11]}}, cal_hum_ofs[11:0]};
            h5 = {{20{cal_hum_ofs[23]}}, cal_hum_ofs[23:12]};
            x = tf - 32'd76800;
            s1 = sra32((ah << 14) - (h4 << 20) - h5 * x + 32'd16384, 15);
            ta = sra32(x * h6, 10);
            ub = sra32(x * h3, 11) + 32'd32768;
            wc = sra32(ta * ub, 10) + 32'd2097152;
            rr = sra32(wc * h2 + 32'd8192, 14);
            x = s1 * rr;
            q = sra32(x, 15);
            x = x - sra32(sra32(q * q, 7) * h1, 4);
            if (x[31])
                x = 32'd0;
            else if (x > 32'd419430400)
                x = 32'd419430400;
            r.hq = x[28:12];
        end
        return r;
    endfunction

    // The caller drops cfg_we after its last write.
    task automatic write_reg(logic [2:0] idx, logic [63:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            bsc_pkg::REG_TEMP: cal_temp = value[47:0];
            bsc_pkg::REG_PRESS_LO: cal_press_lo = value;
            bsc_pkg::REG_PRESS_HI: cal_press_hi = value;
            bsc_pkg::REG_PRESS_P9: cal_p9 = value[15:0];
            bsc_pkg::REG_HUM_MAIN: cal_hum_main = value[39:0];
            bsc_pkg::REG_HUM_OFS: cal_hum_ofs = value[23:0];
            bsc_pkg::REG_HUM_EN: cal_hum_en = value[0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Waits for the pipeline to drain, then loads a full calibration set.
    task automatic load_calibration(logic [47:0] tc_set, logic [63:0] plo, logic [63:0] phi,
                                    logic [15:0] p9, logic [39:0] hmain, logic [23:0] hofs,
                                    logic hen);
        s_axis_tvalid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        write_reg(bsc_pkg::REG_TEMP, {$urandom, $urandom});
        write_reg(bsc_pkg::REG_TEMP, {16'hA5A5, tc_set});
        write_reg(bsc_pkg::REG_PRESS_LO, plo);
        write_reg(bsc_pkg::REG_PRESS_HI, phi);
        write_reg(bsc_pkg::REG_PRESS_P9, {$urandom, 16'($urandom), p9});
        write_reg(bsc_pkg::REG_HUM_MAIN, {24'hFFFFFF, hmain});
        write_reg(bsc_pkg::REG_HUM_OFS, {40'h0, hofs});
        write_reg(bsc_pkg::REG_HUM_EN, {63'h0, hen});
        cfg_we <= 1'b0;
    endtask

    task automatic send_conversion(bsc_pkg::in_t c, logic typed, reading_t want);
        if (idling_on && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= c;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_readings.push_back(typed ? want : compensate(c));
    endtask

    function automatic bsc_pkg::in_t random_conversion();
        bsc_pkg::in_t c;
        if ($urandom_range(0, 9) < 7)
        begin
            // Codes in the range a working sensor reports.
            c.adc_temperature = 20'($urandom_range(380000, 640000));
            c.adc_pressure = 20'($urandom_range(200000, 700000));
            c.adc_humidity = 16'($urandom_range(15000, 50000));
        end
        else
        begin
            c.adc_temperature = 20'($urandom);
            c.adc_pressure = 20'($urandom);
            c.adc_humidity = 16'($urandom);
        end
        return c;
    endfunction

    task automatic random_phase(int count);
        reading_t none;
        none = '0;
        for (int i = 0; i < count; i++)
            send_conversion(random_conversion(), 1'b0, none);
    endtask

    // Sink side: random stall bursts, plus one long hold counted separately.
    always @(posedge clk)
    begin
        if (hold_request && hold_left == 0)
            hold_left <= LONG_HOLD;
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk)
    begin
        if (sink_stall > 0)
            sink_stall <= sink_stall - 1;
        else if (idling_on && $urandom_range(0, 7) == 0)
            sink_stall <= $urandom_range(1, 17);
        m_axis_tready <= rst_n && hold_left == 0 && !(sink_stall > 0);
    end

    always @(posedge clk)
    begin
        reading_t got, want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            got.tc = m_axis_tdata[17:0];
            got.ft = m_axis_tdata[41:18];
            got.pq = m_axis_tdata[73:42];
            got.hq = m_axis_tdata[90:74];
            got.dz = m_axis_tuser;
            if (pending_readings.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected output transaction: %h", got);
            end
            else
            begin
                want = pending_readings.pop_front();
                if (got !== want || m_axis_tdata[95:91] !== 5'd0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Output mismatch: tc %h/%h ft %h/%h pq %h/%h dz %b/%b hq %h/%h",
                                 want.tc, got.tc, want.ft, got.ft, want.pq, got.pq,
                                 want.dz, got.dz, want.hq, got.hq);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Typical calibration of a production part.
    localparam logic [47:0] TYP_TEMP = {16'hFC18, 16'd26435, 16'd27504};
    localparam logic [63:0] TYP_PLO = {16'h0B27, 16'h0BD0, 16'hD643, 16'h8E7D};
    localparam logic [63:0] TYP_PHI = {16'hC6F8, 16'h3C8C, 16'hFFF9, 16'h008C};
    localparam logic [15:0] TYP_P9 = 16'h1770;
    localparam logic [39:0] TYP_HMAIN = {8'h1E, 8'h00, 16'h016A, 8'h4B};
    localparam logic [23:0] TYP_HOFS = {12'h032, 12'h144};

    vector_t reset_rows[4];
    vector_t typ_rows[14];

    initial
    begin
        reading_t zero_cal;
        zero_cal = '0;
        // With every coefficient zero, the pressure divisor is zero.
        zero_cal.dz = 1'b1;
        reset_rows[0] = '{'{16'd0, 20'd0, 20'd0}, 1'b1, zero_cal};
        reset_rows[1] = '{'{16'hFFFF, 20'hFFFFF, 20'hFFFFF}, 1'b1, zero_cal};
        reset_rows[2] = '{'{16'h6A5C, 20'h655AC, 20'h7EED0}, 1'b1, zero_cal};
        reset_rows[3] = '{'{16'h9A53, 20'hAAAAA, 20'h55555}, 1'b1, zero_cal};
        typ_rows[0] = '{'{16'd0, 20'd0, 20'd0}, 1'b0, zero_cal};
        typ_rows[1] = '{'{16'hFFFF, 20'hFFFFF, 20'hFFFFF}, 1'b0, zero_cal};
        typ_rows[2] = '{'{16'hFFFF, 20'd0, 20'hFFFFF}, 1'b0, zero_cal};
        typ_rows[3] = '{'{16'd0, 20'hFFFFF, 20'd0}, 1'b0, zero_cal};
        typ_rows[4] = '{'{16'h6A5C, 20'h655AC, 20'h7EED0}, 1'b0, zero_cal};
        typ_rows[5] = '{'{16'h8000, 20'h80000, 20'h80000}, 1'b0, zero_cal};
        typ_rows[6] = '{'{16'h7FFF, 20'h7FFFF, 20'h7FFFF}, 1'b0, zero_cal};
        typ_rows[7] = '{'{16'h0001, 20'h00001, 20'h00001}, 1'b0, zero_cal};
        typ_rows[8] = '{'{16'hC000, 20'h30000, 20'h60000}, 1'b0, zero_cal};
        typ_rows[9] = '{'{16'h2000, 20'h90000, 20'h90000}, 1'b0, zero_cal};
        typ_rows[10] = '{'{16'hA000, 20'h10000, 20'hF0000}, 1'b0, zero_cal};
        typ_rows[11] = '{'{16'h5555, 20'h55555, 20'hAAAAA}, 1'b0, zero_cal};
        typ_rows[12] = '{'{16'hAAAA, 20'hAAAAA, 20'h55555}, 1'b0, zero_cal};
        typ_rows[13] = '{'{16'h4000, 20'h6D4E0, 20'h7E000}, 1'b0, zero_cal};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (reset_rows[i])
            send_conversion(reset_rows[i].conv, reset_rows[i].typed, reset_rows[i].want);

        load_calibration(TYP_TEMP, TYP_PLO, TYP_PHI, TYP_P9, TYP_HMAIN, TYP_HOFS, 1'b1);
        foreach (typ_rows[i])
            send_conversion(typ_rows[i].conv, typ_rows[i].typed, typ_rows[i].want);

        // The long hold lets the pipeline and input queue fill up.
        hold_request <= 1'b1;
        random_phase(150);
        hold_request <= 1'b0;

        load_calibration('1, '1, '1, '1, '1, '1, 1'b1);
        random_phase(110);

        load_calibration({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                         16'($urandom), {$urandom, $urandom}, 24'($urandom), 1'b1);
        random_phase(110);

        load_calibration(TYP_TEMP, TYP_PLO, TYP_PHI, 16'h8000, {8'h80, 8'hFF, 16'h8000, 8'hFF},
                         {12'h800, 12'h7FF}, 1'b1);
        random_phase(110);

        // Pressure coefficient P1 zero forces the zero divisor.
        load_calibration(TYP_TEMP, {TYP_PLO[63:16], 16'h0000}, TYP_PHI, TYP_P9, TYP_HMAIN,
                         TYP_HOFS, 1'b1);
        random_phase(90);

        load_calibration(TYP_TEMP, TYP_PLO, TYP_PHI, TYP_P9, TYP_HMAIN, TYP_HOFS, 1'b0);
        random_phase(110);

        load_calibration(TYP_TEMP, TYP_PLO, TYP_PHI, TYP_P9, {8'h7F, 8'h00, 16'h7FFF, 8'h7F},
                         {12'h7FF, 12'h800}, 1'b1);
        random_phase(60);
        idling_on = 1'b0;
        random_phase(100);
        s_axis_tvalid <= 1'b0;

        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
